@@ rtl/core/mmcr_pkg.sv @@
// Shared constants, types and the interpolator coefficient table of the timing recovery block.
`default_nettype none

package mmcr_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int TAP_COUNT   = 8;
  localparam int PHASE_STEPS = 128;
  localparam int ROW_COUNT   = PHASE_STEPS + 1;
  localparam int TABLE_DEPTH = ROW_COUNT * TAP_COUNT;
  localparam int HALF_TAPS   = TAP_COUNT / 2;

  localparam int TAP_W     = 16;
  localparam int TAP_FRAC  = 14;
  localparam int ERR_SHIFT = SAMPLE_W - 2;
  localparam int GAIN_W    = 16;
  localparam int PER_W     = 24;
  localparam int LIM_W     = 21;
  localparam int CFG_W     = 24;
  localparam int FILL_W    = 10;
  localparam int PHASE_W   = 16;

  localparam int IDX_W  = $clog2(TAP_COUNT);
  localparam int CNT_W  = $clog2(TAP_COUNT + 2);
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int ROWP_W = PHASE_W + $clog2(PHASE_STEPS) + 2;

  localparam int ERR_W   = SAMPLE_W + 2;
  localparam int MUL_A_W = ERR_W;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = SAMPLE_W + TAP_W + $clog2(TAP_COUNT) + 1;
  localparam int STEP_W  = PROD_W - ERR_SHIFT;
  localparam int WIDE_W  = PER_W + 4;
  localparam int DEV_W   = LIM_W + 1;
  localparam int WHOLE_W = WIDE_W - PHASE_W;
  localparam int FD_W    = WHOLE_W + 2;

  localparam logic [GAIN_W-1:0] PHASE_GAIN_RST  = GAIN_W'(9830);
  localparam logic [GAIN_W-1:0] PERIOD_GAIN_RST = GAIN_W'(52429);
  localparam logic [PER_W-1:0]  PERIOD_NOM_RST  = PER_W'(262144);
  localparam logic [LIM_W-1:0]  PERIOD_LIM_RST  = LIM_W'(262);
  localparam logic [PHASE_W-1:0] PHASE_RST      = {1'b1, {(PHASE_W-1){1'b0}}};

  localparam logic signed [FILL_W-1:0] FILL_MAX = {1'b0, {(FILL_W-1){1'b1}}};
  localparam logic signed [FILL_W-1:0] FILL_MIN = {1'b1, {(FILL_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [PHASE_W:0] PH_ONE = {1'b1, {PHASE_W{1'b0}}};
  localparam logic [ROWP_W-1:0] PH_HALF = ROWP_W'(1) << (PHASE_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (TAP_FRAC - 1);
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (ERR_SHIFT - 1);

  typedef enum logic [1:0] {
    REG_PHASE_GAIN,
    REG_PERIOD_GAIN,
    REG_PERIOD_NOMINAL,
    REG_PERIOD_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_TAP,
    MUL_PGAIN,
    MUL_PHGAIN
  } mul_op_t;

  typedef struct packed {
    logic             accept;
    logic             row_load;
    logic             rd_en;
    logic [IDX_W-1:0] tap_idx;
    mul_op_t          mul_op;
    logic             acc_en;
    logic             sym_load;
    logic             err_load;
    logic             dev_load;
    logic             period_load;
    logic             phase_load;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic out_free;
  } dp_status_t;

  typedef logic signed [TAP_W-1:0] tap_table_t [TABLE_DEPTH];

  // Quotient truncated toward zero, formed by restoring long division on the magnitudes.
  function automatic longint div_trunc(input longint num, input longint den);
    longint n_mag;
    longint d_mag;
    longint q;
    longint r;
    logic   neg;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    neg   = (num < 0) != (den < 0);
    q     = 0;
    r     = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((n_mag >>> b) & longint'(1));
      q = q <<< 1;
      if (r >= d_mag) begin
        r = r - d_mag;
        q = q | longint'(1);
      end
    end
    return neg ? -q : q;
  endfunction

  // Lagrange weights for the point TAP_COUNT/2 - s/PHASE_STEPS, Q1.14.
  function automatic tap_table_t build_taps();
    tap_table_t t;
    longint     acc;
    longint     base;
    longint     rnd;
    longint     p;
    p = longint'(PHASE_STEPS);
    for (int s = 0; s < ROW_COUNT; s++) begin
      base = longint'(HALF_TAPS) * p - longint'(s);
      for (int k = 0; k < TAP_COUNT; k++) begin
        acc = longint'(1) <<< 30;
        for (int j = 0; j < TAP_COUNT; j++) begin
          if (j != k) begin
            acc = div_trunc(acc * (base - longint'(j) * p), p * longint'(k - j));
          end
        end
        rnd = (acc + longint'(32768)) >>> 16;
        if (rnd > longint'(32767)) begin
          rnd = longint'(32767);
        end else if (rnd < -longint'(32768)) begin
          rnd = -longint'(32768);
        end
        t[s * TAP_COUNT + k] = TAP_W'(rnd);
      end
    end
    return t;
  endfunction

  localparam tap_table_t TAP_TABLE = build_taps();

endpackage

`default_nettype wire

@@ rtl/core/mmcr_stream_if.sv @@
// Valid/ready stream interfaces for the sample and symbol channels.
`default_nettype none

interface mmcr_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmcr_pkg::SAMPLE_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface mmcr_symbol_if;
  logic                                valid;
  logic                                ready;
  logic signed [mmcr_pkg::SAMPLE_W-1:0] symbol;
  modport source(output valid, output symbol, input ready);
  modport sink(input valid, input symbol, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mueller_muller_clock_recovery_top.sv @@
// Top level of the Mueller-Muller symbol timing recovery block.
`default_nettype none

// Each transfer on in_if shifts one Q1.14 sample into an 8-tap delay line. A sample that
// leaves the fill count below the tap count gives no symbol. For a sample that completes a
// symbol, the dot product runs one tap a cycle through the registered coefficient ROM read
// and the single shared 18x17 multiplier, which then also forms the period and phase gain
// products of the loop update. The symbol sits in an output register, so the next
// sample is taken while it waits on out_if; a later symbol waits at the error update
// until that register is free.
// The interpolator table is a constant ROM, so no clearing pass follows reset.
// Configuration writes on cfg_we go to the register picked by cfg_index.

module mueller_muller_clock_recovery_top (
  input  logic                        clk,
  input  logic                        rst_n,
  mmcr_sample_if.sink                 in_if,
  mmcr_symbol_if.source               out_if,
  input  logic                        cfg_we,
  input  mmcr_pkg::cfg_reg_t          cfg_index,
  input  logic [mmcr_pkg::CFG_W-1:0]  cfg_data
);

  mmcr_pkg::dp_cmd_t    cmd;
  mmcr_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic signed [mmcr_pkg::SAMPLE_W-1:0] out_symbol;

  assign in_if.ready   = in_ready;
  assign out_if.valid  = out_valid;
  assign out_if.symbol = out_symbol;

  mmcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mmcr_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (in_if.sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_if.ready),
    .out_valid  (out_valid),
    .out_symbol (out_symbol)
  );

endmodule

`default_nettype wire

@@ rtl/core/mmcr_ctrl.sv @@
// Sequencing state machine of the timing recovery block.
`default_nettype none

module mmcr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mmcr_pkg::dp_status_t status,
  output mmcr_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_SYM,
    ST_ERR,
    ST_PGAIN,
    ST_NEXT,
    ST_PERIOD,
    ST_PHASE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [mmcr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.fill_full) begin
          cmd.row_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_MAC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MAC: begin
        if (cnt_r < mmcr_pkg::CNT_W'(mmcr_pkg::TAP_COUNT)) begin
          cmd.rd_en   = 1'b1;
          cmd.tap_idx = cnt_r[mmcr_pkg::IDX_W-1:0];
        end
        if (cnt_r >= mmcr_pkg::CNT_W'(1) &&
            cnt_r <= mmcr_pkg::CNT_W'(mmcr_pkg::TAP_COUNT)) begin
          cmd.mul_op = mmcr_pkg::MUL_TAP;
        end
        if (cnt_r >= mmcr_pkg::CNT_W'(2)) begin
          cmd.acc_en = 1'b1;
        end
        if (cnt_r == mmcr_pkg::CNT_W'(mmcr_pkg::TAP_COUNT + 1)) begin
          state_nxt = ST_SYM;
        end else begin
          cnt_nxt = mmcr_pkg::CNT_W'(cnt_r + 1'b1);
        end
      end
      ST_SYM: begin
        cmd.sym_load = 1'b1;
        state_nxt    = ST_ERR;
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.err_load = 1'b1;
          state_nxt    = ST_PGAIN;
        end
      end
      ST_PGAIN: begin
        cmd.mul_op = mmcr_pkg::MUL_PGAIN;
        state_nxt  = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.dev_load = 1'b1;
        cmd.mul_op   = mmcr_pkg::MUL_PHGAIN;
        state_nxt    = ST_PERIOD;
      end
      ST_PERIOD: begin
        cmd.period_load = 1'b1;
        state_nxt       = ST_PHASE;
      end
      ST_PHASE: begin
        cmd.phase_load = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mmcr_datapath.sv @@
// Delay line, coefficient ROM, shared multiplier and loop registers of the timing recovery block.
`default_nettype none

module mmcr_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mmcr_pkg::dp_cmd_t                    cmd,
  output mmcr_pkg::dp_status_t                 status,
  input  logic signed [mmcr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 cfg_we,
  input  mmcr_pkg::cfg_reg_t                   cfg_index,
  input  logic [mmcr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [mmcr_pkg::SAMPLE_W-1:0] out_symbol
);

  localparam int SW  = mmcr_pkg::SAMPLE_W;
  localparam int WW  = mmcr_pkg::WIDE_W;
  localparam int TC  = mmcr_pkg::TAP_COUNT;

  // Loop state and configuration.
  logic signed [SW-1:0]                   dl_r [TC];
  logic signed [mmcr_pkg::FILL_W-1:0]     fill_r;
  logic [mmcr_pkg::PHASE_W-1:0]           phase_r;
  logic [mmcr_pkg::PER_W-1:0]             period_now_r;
  logic signed [SW-1:0]                   prev_r;
  logic [mmcr_pkg::GAIN_W-1:0]            ph_gain_r;
  logic [mmcr_pkg::GAIN_W-1:0]            per_gain_r;
  logic [mmcr_pkg::PER_W-1:0]             per_nom_r;
  logic [mmcr_pkg::LIM_W-1:0]             per_lim_r;
  logic                                   out_valid_r;

  // Working registers.
  logic [mmcr_pkg::ROW_W-1:0]             row_r;
  logic [mmcr_pkg::IDX_W-1:0]             idx_r;
  logic signed [mmcr_pkg::TAP_W-1:0]      rom_q_r;
  logic signed [mmcr_pkg::PROD_W-1:0]     prod_r;
  logic signed [mmcr_pkg::ACC_W-1:0]      acc_r;
  logic signed [SW-1:0]                   sym_r;
  logic signed [mmcr_pkg::ERR_W-1:0]      err_r;
  logic signed [mmcr_pkg::DEV_W-1:0]      dev_r;
  logic signed [mmcr_pkg::STEP_W-1:0]     phstep_r;
  logic signed [SW-1:0]                   out_symbol_r;

  // Combinational terms.
  logic signed [mmcr_pkg::FILL_W-1:0]     fill_inc;
  logic [mmcr_pkg::PHASE_W:0]             ph_diff;
  logic [mmcr_pkg::ROWP_W-1:0]            rowp;
  logic [mmcr_pkg::ROWP_W-mmcr_pkg::PHASE_W-1:0] row_full;
  logic [mmcr_pkg::ROW_W-1:0]             row_nxt;
  logic [mmcr_pkg::ADDR_W-1:0]            rom_addr;
  logic signed [mmcr_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [mmcr_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [mmcr_pkg::PROD_W-1:0]     mul_p;
  logic signed [mmcr_pkg::ACC_W-1:0]      acc_rnd;
  logic signed [SW-1:0]                   sym_nxt;
  logic signed [mmcr_pkg::ERR_W-1:0]      psym;
  logic signed [mmcr_pkg::ERR_W-1:0]      pprev;
  logic signed [mmcr_pkg::ERR_W-1:0]      err_nxt;
  logic signed [mmcr_pkg::PROD_W-1:0]     prod_rnd;
  logic signed [mmcr_pkg::STEP_W-1:0]     step;
  logic signed [WW-1:0]                   per_w;
  logic signed [WW-1:0]                   nom_w;
  logic signed [WW-1:0]                   lim_w;
  logic signed [WW-1:0]                   diff_w;
  logic signed [WW-1:0]                   dev_sel;
  logic signed [WW-1:0]                   psum_w;
  logic signed [WW-1:0]                   per_max_w;
  logic [mmcr_pkg::PER_W-1:0]             period_nxt;
  logic signed [WW-1:0]                   m_w;
  logic signed [mmcr_pkg::WHOLE_W-1:0]    whole;
  logic signed [mmcr_pkg::FD_W-1:0]       fdiff;
  logic signed [mmcr_pkg::FILL_W-1:0]     fill_nxt;

  assign fill_inc = (fill_r == mmcr_pkg::FILL_MAX) ? fill_r
                  : mmcr_pkg::FILL_W'(fill_r + mmcr_pkg::FILL_W'(1));

  // Row select: round((1 - phase) * PHASE_STEPS).
  assign ph_diff  = mmcr_pkg::PH_ONE - {1'b0, phase_r};
  assign rowp     = mmcr_pkg::ROWP_W'(ph_diff) * mmcr_pkg::ROWP_W'(mmcr_pkg::PHASE_STEPS)
                  + mmcr_pkg::PH_HALF;
  assign row_full = rowp[mmcr_pkg::ROWP_W-1:mmcr_pkg::PHASE_W];
  assign row_nxt  = (row_full > (mmcr_pkg::ROWP_W-mmcr_pkg::PHASE_W)'(mmcr_pkg::PHASE_STEPS))
                  ? mmcr_pkg::ROW_W'(mmcr_pkg::PHASE_STEPS)
                  : row_full[mmcr_pkg::ROW_W-1:0];

  assign rom_addr = mmcr_pkg::ADDR_W'(mmcr_pkg::ADDR_W'(row_r) * mmcr_pkg::ADDR_W'(TC)
                  + mmcr_pkg::ADDR_W'(cmd.tap_idx));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      mmcr_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      mmcr_pkg::MUL_TAP: begin
        mul_a = mmcr_pkg::MUL_A_W'(dl_r[idx_r]);
        mul_b = mmcr_pkg::MUL_B_W'(rom_q_r);
      end
      mmcr_pkg::MUL_PGAIN: begin
        mul_a = err_r;
        mul_b = signed'({1'b0, per_gain_r});
      end
      mmcr_pkg::MUL_PHGAIN: begin
        mul_a = err_r;
        mul_b = signed'({1'b0, ph_gain_r});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Symbol rounding and saturation.
  assign acc_rnd = (acc_r + mmcr_pkg::ACC_HALF) >>> mmcr_pkg::TAP_FRAC;
  assign sym_nxt = (acc_rnd > mmcr_pkg::ACC_W'(mmcr_pkg::SMAX)) ? mmcr_pkg::SMAX
                 : (acc_rnd < mmcr_pkg::ACC_W'(mmcr_pkg::SMIN)) ? mmcr_pkg::SMIN
                 : acc_rnd[SW-1:0];

  // Mueller-Muller timing error.
  assign psym    = prev_r[SW-1] ? -mmcr_pkg::ERR_W'(sym_r) : mmcr_pkg::ERR_W'(sym_r);
  assign pprev   = sym_r[SW-1] ? -mmcr_pkg::ERR_W'(prev_r) : mmcr_pkg::ERR_W'(prev_r);
  assign err_nxt = psym - pprev;

  // Loop gain step from the shared product.
  assign prod_rnd = (prod_r + mmcr_pkg::PROD_HALF) >>> mmcr_pkg::ERR_SHIFT;
  assign step     = prod_rnd[mmcr_pkg::STEP_W-1:0];

  // Period update with clamp about nominal.
  assign per_w     = WW'(signed'({1'b0, period_now_r}));
  assign nom_w     = WW'(signed'({1'b0, per_nom_r}));
  assign lim_w     = WW'(signed'({1'b0, per_lim_r}));
  assign diff_w    = per_w + WW'(step) - nom_w;
  assign dev_sel   = (diff_w > lim_w) ? lim_w : (diff_w < -lim_w) ? -lim_w : diff_w;
  assign psum_w    = nom_w + WW'(dev_r);
  assign per_max_w = WW'(signed'({1'b0, {mmcr_pkg::PER_W{1'b1}}}));
  assign period_nxt = (psum_w < WW'(0)) ? '0
                    : (psum_w > per_max_w) ? {mmcr_pkg::PER_W{1'b1}}
                    : psum_w[mmcr_pkg::PER_W-1:0];

  // Phase advance; the integer part comes off the fill count.
  assign m_w   = WW'(signed'({1'b0, phase_r})) + per_w + WW'(phstep_r);
  assign whole = m_w[WW-1:mmcr_pkg::PHASE_W];
  assign fdiff = mmcr_pkg::FD_W'(fill_r) - mmcr_pkg::FD_W'(whole);
  assign fill_nxt = (fdiff > mmcr_pkg::FD_W'(mmcr_pkg::FILL_MAX)) ? mmcr_pkg::FILL_MAX
                  : (fdiff < mmcr_pkg::FD_W'(mmcr_pkg::FILL_MIN)) ? mmcr_pkg::FILL_MIN
                  : fdiff[mmcr_pkg::FILL_W-1:0];

  assign status.fill_full = (fill_r >= signed'(mmcr_pkg::FILL_W'(TC)));
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TC; k++) begin
        dl_r[k] <= '0;
      end
      fill_r       <= '0;
      phase_r      <= mmcr_pkg::PHASE_RST;
      period_now_r <= mmcr_pkg::PERIOD_NOM_RST;
      prev_r       <= '0;
      ph_gain_r    <= mmcr_pkg::PHASE_GAIN_RST;
      per_gain_r   <= mmcr_pkg::PERIOD_GAIN_RST;
      per_nom_r    <= mmcr_pkg::PERIOD_NOM_RST;
      per_lim_r    <= mmcr_pkg::PERIOD_LIM_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        for (int k = 0; k < TC - 1; k++) begin
          dl_r[k] <= dl_r[k+1];
        end
        dl_r[TC-1] <= in_sample;
        fill_r     <= fill_inc;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          mmcr_pkg::REG_PHASE_GAIN:     ph_gain_r  <= cfg_data[mmcr_pkg::GAIN_W-1:0];
          mmcr_pkg::REG_PERIOD_GAIN:    per_gain_r <= cfg_data[mmcr_pkg::GAIN_W-1:0];
          mmcr_pkg::REG_PERIOD_NOMINAL: per_nom_r  <= cfg_data[mmcr_pkg::PER_W-1:0];
          mmcr_pkg::REG_PERIOD_LIMIT:   per_lim_r  <= cfg_data[mmcr_pkg::LIM_W-1:0];
        endcase
      end
      if (cmd.err_load) begin
        prev_r <= sym_r;
      end
      if (cmd.period_load) begin
        period_now_r <= period_nxt;
      end
      if (cmd.phase_load) begin
        phase_r <= m_w[mmcr_pkg::PHASE_W-1:0];
        fill_r  <= fill_nxt;
      end
      if (cmd.err_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      row_r <= row_nxt;
    end
    if (cmd.rd_en) begin
      rom_q_r <= mmcr_pkg::TAP_TABLE[rom_addr];
      idx_r   <= cmd.tap_idx;
    end
    if (cmd.mul_op != mmcr_pkg::MUL_NONE) begin
      prod_r <= mul_p;
    end
    if (cmd.row_load) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + mmcr_pkg::ACC_W'(prod_r);
    end
    if (cmd.sym_load) begin
      sym_r <= sym_nxt;
    end
    if (cmd.err_load) begin
      err_r        <= err_nxt;
      out_symbol_r <= sym_r;
    end
    if (cmd.dev_load) begin
      dev_r <= dev_sel[mmcr_pkg::DEV_W-1:0];
    end
    if (cmd.period_load) begin
      phstep_r <= step;
    end
  end

  a_row_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (row_r <= mmcr_pkg::ROW_W'(mmcr_pkg::PHASE_STEPS)))
    else $error("interpolator row beyond the coefficient table");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_load |=> (acc_r == '0))
    else $error("accumulator not cleared before the dot product");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err_load |=> (out_valid_r && out_symbol_r == $past(sym_r)))
    else $error("symbol not presented after the error update");

  a_dev_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dev_load |=> (WW'(dev_r) <= lim_w && WW'(dev_r) >= -lim_w))
    else $error("period deviation outside the configured limit");

  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.err_load |=> (err_r <= mmcr_pkg::ERR_W'((2 ** SW) - 1) &&
                      err_r >= -mmcr_pkg::ERR_W'((2 ** SW) - 1)))
    else $error("timing error outside its range");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the Mueller-Muller symbol timing recovery block.

module testbench;
  import mmcr_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int TAPS          = 8;
  localparam int STEPS         = 128;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SHOWN_FAULTS  = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_SYMBOL,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cfg_reg_t   sel;
    logic [23:0] data;
    sample_t    smp;
    sample_t    sym;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [23:0] cfg_data;

  mmcr_sample_if in_if ();
  mmcr_symbol_if out_if ();

  mueller_muller_clock_recovery_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state and its copy of the registers.
  logic signed [15:0] weights [0:STEPS][0:TAPS-1];
  sample_t            history [0:TAPS-1];
  longint             fill_lvl;
  longint             mu;
  longint             period_cur;
  longint             last_sym;
  logic [15:0]        k_phase;
  logic [15:0]        k_period;
  logic [23:0]        nom_period;
  logic [20:0]        lim_period;

  sample_t symbol_q [$];
  int      fault_count;
  int      symbols_checked;
  int      samples_sent;
  int      writes_done;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      quiet_cycles;

  // Shape of the random sample stream.
  int amp;
  int noise;
  int hold_len;
  int run_left;
  int level;

  // Directed stimulus. The zero-phase rows pick the integer-point row, which passes the
  // fourth-oldest sample straight through.
  step_row_t directed_rows [31] = '{
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_SYMBOL,  REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_GAIN,    24'd0,       16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_NOMINAL, 24'd98304,   16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_LIMIT,   24'd0,       16'sd0,      16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd32767,  16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sh8000,   16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd1,      16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       -16'sd1,     16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd12345,  16'sd0},
    '{ROW_SYMBOL,  REG_PHASE_GAIN,     24'd0,       -16'sd20000, 16'sh8000},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sd100,    16'sd0},
    '{ROW_SILENT,  REG_PHASE_GAIN,     24'd0,       16'sd32767,  16'sd0},
    '{ROW_SYMBOL,  REG_PHASE_GAIN,     24'd0,       16'sd7,      16'sd12345},
    '{ROW_WRITE,   REG_PHASE_GAIN,     24'd65535,   16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_GAIN,    24'd65535,   16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_NOMINAL, 24'd65536,   16'sd0,      16'sd0},
    '{ROW_WRITE,   REG_PERIOD_LIMIT,   24'd1048576, 16'sd0,      16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sd32767,  16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sd32767,  16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sd0,      16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sh8000,   16'sd0},
    '{ROW_PREDICT, REG_PHASE_GAIN,     24'd0,       16'sh8000,   16'sd0}
  };

  int phase_items [6] = '{250, 300, 250, 300, 300, 250};

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Floor of x / 2^n after adding one half.
  function automatic longint rnd_shift(input longint x, input int n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  // Lagrange weights for the point TAPS/2 - r/STEPS, with truncating division at each factor.
  function automatic void fill_weights();
    longint pt;
    longint w;
    for (int r = 0; r <= STEPS; r++) begin
      pt = longint'((TAPS / 2) * STEPS - r);
      for (int k = 0; k < TAPS; k++) begin
        w = longint'(1) <<< 30;
        for (int j = 0; j < TAPS; j++) begin
          if (j != k) begin
            w = w * (pt - longint'(j * STEPS)) / longint'(STEPS * (k - j));
          end
        end
        weights[r][k] = 16'(clip(rnd_shift(w, 16), -32768, 32767));
      end
    end
  endfunction

  function automatic void reset_model();
    fill_weights();
    foreach (history[k]) history[k] = '0;
    fill_lvl   = 0;
    mu         = 32768;
    k_phase    = 16'd9830;
    k_period   = 16'd52429;
    nom_period = 24'd262144;
    lim_period = 21'd262;
    period_cur = 262144;
    last_sym   = 0;
  endfunction

  // Shifts one sample in and returns 1 when it completes a symbol.
  function automatic bit predict_symbol(input sample_t x, output sample_t y);
    longint row;
    longint dot;
    longint sym;
    longint err;
    longint nxt;
    longint dev;
    longint advance;
    longint whole;
    y = '0;
    for (int k = 0; k < TAPS - 1; k++) history[k] = history[k + 1];
    history[TAPS - 1] = x;
    fill_lvl = clip(fill_lvl + 1, -512, 511);
    if (fill_lvl < TAPS) begin
      return 1'b0;
    end
    row = clip(rnd_shift((65536 - mu) * STEPS, 16), 0, STEPS);
    dot = 0;
    for (int k = 0; k < TAPS; k++) begin
      dot += longint'(history[k]) * longint'(weights[row][k]);
    end
    sym = clip(rnd_shift(dot, 14), -32768, 32767);
    y = 16'(sym);
    err = ((last_sym < 0) ? -sym : sym) - ((sym < 0) ? -last_sym : last_sym);
    last_sym = sym;
    nxt = period_cur + rnd_shift(longint'(k_period) * err, SAMPLE_W - 2);
    dev = clip(nxt - longint'(nom_period), -longint'(lim_period), longint'(lim_period));
    period_cur = clip(longint'(nom_period) + dev, 0, 16777215);
    advance = mu + period_cur + rnd_shift(longint'(k_phase) * err, SAMPLE_W - 2);
    whole = advance >>> 16;
    mu = advance - whole * 65536;
    fill_lvl = clip(fill_lvl - whole, -512, 511);
    return 1'b1;
  endfunction

  // Bursts of a held level with noise, broken up by samples drawn over the full range.
  function automatic sample_t next_stream_sample();
    int v;
    if ($urandom_range(3) == 0) begin
      return 16'($urandom);
    end
    if (run_left == 0) begin
      level = $urandom_range(1) ? amp : -amp;
      run_left = hold_len + $urandom_range(1);
    end
    run_left--;
    v = level + int'($urandom_range(2 * noise)) - noise;
    return 16'(clip(v, -32768, 32767));
  endfunction

  function automatic void set_regime(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 33;
        recv_idle_pct = 73;
      end
      1: begin
        send_idle_pct = 73;
        recv_idle_pct = 33;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic send_sample(input sample_t value, input row_kind_t kind, input sample_t typed);
    sample_t predicted;
    bit      produced;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    produced = predict_symbol(value, predicted);
    if (kind == ROW_SYMBOL) begin
      symbol_q.push_back(typed);
    end else if (kind == ROW_PREDICT && produced) begin
      symbol_q.push_back(predicted);
    end
    samples_sent++;
    @(negedge clk);
  endtask

  // Waits until every symbol has arrived and the block has had time to go idle.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (symbol_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [23:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    case (sel)
      REG_PHASE_GAIN:     k_phase = value[15:0];
      REG_PERIOD_GAIN:    k_period = value[15:0];
      REG_PERIOD_NOMINAL: nom_period = value[23:0];
      REG_PERIOD_LIMIT:   lim_period = value[20:0];
      default: ;
    endcase
    writes_done++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (symbol_q.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
          $display("unexpected symbol %0d with nothing outstanding", out_if.symbol);
        end
      end else begin
        if (out_if.symbol !== symbol_q[0]) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $display("symbol %0d mismatch: expected %0d, got %0d",
                     symbols_checked, symbol_q[0], out_if.symbol);
          end
        end
        void'(symbol_q.pop_front());
      end
      symbols_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d symbols outstanding",
               quiet_cycles, symbol_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int random_total;
    int random_idx;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_PHASE_GAIN;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    fault_count     = 0;
    symbols_checked = 0;
    samples_sent    = 0;
    writes_done     = 0;
    quiet_cycles    = 0;
    run_left        = 0;
    level           = 0;
    random_idx      = 0;
    random_total    = 0;
    foreach (phase_items[p]) random_total += phase_items[p];
    set_regime(0);
    reset_model();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].sel, directed_rows[i].data);
      end else begin
        send_sample(directed_rows[i].smp, directed_rows[i].kind, directed_rows[i].sym);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_PHASE_GAIN, 24'd9830);
          write_reg(REG_PERIOD_GAIN, 24'd52429);
          write_reg(REG_PERIOD_NOMINAL, 24'd262144);
          write_reg(REG_PERIOD_LIMIT, 24'd262);
        end
        1: begin
          write_reg(REG_PHASE_GAIN, 24'd65535);
          write_reg(REG_PERIOD_GAIN, 24'd65535);
          write_reg(REG_PERIOD_NOMINAL, 24'd16777215);
          write_reg(REG_PERIOD_LIMIT, 24'd1048576);
        end
        2: begin
          write_reg(REG_PHASE_GAIN, 24'd0);
          write_reg(REG_PERIOD_GAIN, 24'd0);
          write_reg(REG_PERIOD_NOMINAL, 24'd65536);
          write_reg(REG_PERIOD_LIMIT, 24'd0);
        end
        4: begin
          write_reg(REG_PHASE_GAIN, 24'd65535);
          write_reg(REG_PERIOD_GAIN, 24'd32768);
          write_reg(REG_PERIOD_NOMINAL, 24'd98304);
          write_reg(REG_PERIOD_LIMIT, 24'd1048576);
        end
        default: begin
          write_reg(REG_PHASE_GAIN, 24'($urandom_range(65535)));
          write_reg(REG_PERIOD_GAIN, 24'($urandom_range(65535)));
          write_reg(REG_PERIOD_NOMINAL,
                    24'($urandom_range((p == 3 ? 6 : 16) * 65536, 65536)));
          write_reg(REG_PERIOD_LIMIT, 24'($urandom_range(1048576)));
        end
      endcase
      amp      = $urandom_range(32767, 256);
      noise    = $urandom_range(4096);
      hold_len = (nom_period >> 16 > 0) ? int'(nom_period >> 16) : 1;
      run_left = 0;
      for (int i = 0; i < phase_items[p]; i++) begin
        set_regime(random_idx * 3 / random_total);
        send_sample(next_stream_sample(), ROW_PREDICT, '0);
        random_idx++;
      end
    end

    settle();
    $display("Sent %0d samples and checked %0d symbols over %0d register writes,",
             samples_sent, symbols_checked, writes_done);
    $display("with gain, period and limit settings from zero to full scale.");
    if (fault_count == 0 && symbol_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d faults, %0d symbols outstanding", fault_count, symbol_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
